### sv/kmd_pkg.sv
// ----------------------------------------------------------------------------
// kmd_pkg - keypad matrix decoder package
// Payload types, keymaps and mode codes shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

    localparam int NUM_KEYS     = 15;
    localparam int MODE_KEY_BIT = 15;

    typedef logic [7:0]  key_code_t;
    typedef logic [1:0]  mode_code_t;
    typedef logic [15:0] debounce_t;

    localparam debounce_t  DEBOUNCE_RESET = 16'd200;
    localparam mode_code_t MODE_ONE       = 2'd1;
    localparam mode_code_t MODE_TWO       = 2'd2;

    typedef struct packed {
        logic [15:0] key_matrix;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        key_code_t  key_code;
        mode_code_t mode_now;
    } out_item_t;

    // mode_sel: 0 is mode 1, 1 is mode 2
    typedef struct packed {
        logic mode_sel;
        logic mode_sel_after;
    } mode_status_t;

    // keymaps by bit index 0..14
    localparam key_code_t MAP_ONE [NUM_KEYS] = '{
        "1", "2", "3", "A", "4", "5", "6", "B", "7", "8", "9", "C", "*", "0", "#"
    };
    localparam key_code_t MAP_TWO [NUM_KEYS] = '{
        8'd12, 8'd22, 8'd32, "X", 8'd42, 8'd52, 8'd62, "Y",
        8'd72, 8'd82, 8'd92, "Z", "S", 8'd20, "T"
    };

endpackage

`default_nettype wire

### sv/kmd_keymap.sv
// ----------------------------------------------------------------------------
// kmd_keymap - ordinary key decode
// Gives the code of the single pressed ordinary key, 0 for none, several,
// or while the mode key is down.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_keymap
(
    input  wire logic [15:0]       key_matrix,
    input  wire logic              mode_sel,
    output kmd_pkg::key_code_t     key_code
);

    logic [kmd_pkg::NUM_KEYS-1:0] ord;
    logic                         single;
    kmd_pkg::key_code_t           code_or;

    assign ord    = key_matrix[kmd_pkg::NUM_KEYS-1:0];
    assign single = (ord != '0)
                    && ((ord & (ord - {{(kmd_pkg::NUM_KEYS-1){1'b0}}, 1'b1})) == '0);

    // one-hot select: an OR over independent entries
    always_comb
    begin
        code_or = '0;
        for (int i = 0; i < kmd_pkg::NUM_KEYS; i++)
        begin
            if (ord[i])
            begin
                code_or = code_or | (mode_sel ? kmd_pkg::MAP_TWO[i] : kmd_pkg::MAP_ONE[i]);
            end
        end
    end

    assign key_code = (!key_matrix[kmd_pkg::MODE_KEY_BIT] && single) ? code_or : '0;

endmodule

`default_nettype wire

### sv/kmd_mode_ctrl.sv
// ----------------------------------------------------------------------------
// kmd_mode_ctrl - mode key state
// Holds the keymap mode, the tick of the last toggle and the held flag;
// toggles on a debounced fresh press of the mode key.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_mode_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                mode_key,
    input  wire logic [31:0]         time_ms,
    input  wire kmd_pkg::debounce_t  debounce,
    output kmd_pkg::mode_status_t    status
);

    logic        mode_reg,        mode_next;
    logic [31:0] last_toggle_reg, last_toggle_next;
    logic        held_reg,        held_next;
    logic [31:0] elapsed;
    logic        toggle;

    // wraps at 32 bits
    assign elapsed = time_ms - last_toggle_reg;
    assign toggle  = mode_key && !held_reg && (elapsed >= {16'd0, debounce});

    always_comb
    begin
        mode_next        = mode_reg;
        last_toggle_next = last_toggle_reg;
        held_next        = held_reg;
        if (toggle)
        begin
            mode_next        = ~mode_reg;
            last_toggle_next = time_ms;
            held_next        = 1'b1;
        end
        else if (!mode_key)
        begin
            held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            last_toggle_reg <= '0;
            held_reg        <= 1'b0;
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            last_toggle_reg <= last_toggle_next;
            held_reg        <= held_next;
        end
    end

    assign status.mode_sel       = mode_reg;
    assign status.mode_sel_after = mode_next;

endmodule

`default_nettype wire

### sv/keypad_matrix_decoder_two_modes.sv
// ----------------------------------------------------------------------------
// keypad_matrix_decoder_two_modes - 4x4 keypad decoder with two keymaps
// Decodes one key matrix snapshot per transfer into a key code and the mode.
// ----------------------------------------------------------------------------
//  channel   | signals                        | handshake
//  in        | in_data (key_matrix, time_ms)  | in_valid / in_ready
//  out       | out_data (key_code, mode_now)  | out_valid / out_ready
//  cfg       | cfg_wr_data (mode_debounce_ms) | cfg_wr_en, no wait
//
//  One snapshot per cycle unless the result stalls; input then result register.
//  Mode state updates as a snapshot moves from the input to the result register.
//  Reset clears the mode to 1, the toggle tick to 0 and the debounce to 200 ms.
//  A stalled result holds the input register; in_ready drops only when both are
//  full and the result is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_matrix_decoder_two_modes
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire kmd_pkg::in_item_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output kmd_pkg::out_item_t       out_data,
    input  wire logic                cfg_wr_en,
    input  wire kmd_pkg::debounce_t  cfg_wr_data
);

    kmd_pkg::debounce_t    debounce_reg;
    logic                  s1_valid_reg;
    kmd_pkg::in_item_t     s1_data_reg;
    logic                  out_valid_reg;
    kmd_pkg::out_item_t    out_data_reg;
    kmd_pkg::out_item_t    out_data_next;
    kmd_pkg::mode_status_t status;
    kmd_pkg::key_code_t    key_code;
    logic                  advance;
    logic                  step;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= kmd_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            debounce_reg <= cfg_wr_data;
        end
    end

    kmd_mode_ctrl u_mode_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .mode_key (s1_data_reg.key_matrix[kmd_pkg::MODE_KEY_BIT]),
        .time_ms  (s1_data_reg.time_ms),
        .debounce (debounce_reg),
        .status   (status)
    );

    kmd_keymap u_keymap
    (
        .key_matrix (s1_data_reg.key_matrix),
        .mode_sel   (status.mode_sel),
        .key_code   (key_code)
    );

    always_comb
    begin
        out_data_next.key_code = key_code;
        out_data_next.mode_now = status.mode_sel_after ? kmd_pkg::MODE_TWO
                                                       : kmd_pkg::MODE_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_data_reg <= in_data;
        end
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### sv/kmd_checker.sv
// ----------------------------------------------------------------------------
// kmd_checker - port-level checks for the keypad decoder
// Watches the scan and result channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_checker
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire kmd_pkg::in_item_t   in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire kmd_pkg::out_item_t  out_data
);

    // offered scan holds until its transfer
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_valid && $stable(in_data)))
        else $error("scan changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.mode_now == kmd_pkg::MODE_ONE ||
                       out_data.mode_now == kmd_pkg::MODE_TWO))
        else $error("mode out of range");

    // letter keys belong to one keymap only
    a_map_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.key_code == 8'h41 || out_data.key_code == 8'h42 ||
                       out_data.key_code == 8'h43))
        |-> (out_data.mode_now == kmd_pkg::MODE_ONE))
        else $error("mode 1 code with mode 2");

    a_map_two: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.key_code == 8'h58 || out_data.key_code == 8'h59 ||
                       out_data.key_code == 8'h5A))
        |-> (out_data.mode_now == kmd_pkg::MODE_TWO))
        else $error("mode 2 code with mode 1");

endmodule

bind keypad_matrix_decoder_two_modes kmd_checker u_kmd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
);

`default_nettype wire

### test/tb_keypad_matrix_decoder_two_modes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypad_matrix_decoder_two_modes - self-checking bench for the keypad decoder
// A pinned table of scans runs first: single keys in both keymaps, no key,
// several keys, mode key early, on time, held, and across the 32-bit tick wrap.
// Random scans follow in phases with different debounce settings and
// sender/receiver idle mixes. Results are checked by table or by a local decoder.
// ----------------------------------------------------------------------------

module tb_keypad_matrix_decoder_two_modes;

    localparam int STALL_LIMIT = 2000;
    localparam int NUM_ROWS    = 25;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_SCANS = 125;

    typedef struct packed {
        kmd_pkg::in_item_t  scan;
        logic               pinned;
        kmd_pkg::out_item_t want;
    } scan_row_t;

    localparam kmd_pkg::key_code_t KEYMAP_ONE [15] = '{
        "1", "2", "3", "A", "4", "5", "6", "B", "7", "8", "9", "C", "*", "0", "#"
    };
    localparam kmd_pkg::key_code_t KEYMAP_TWO [15] = '{
        8'd12, 8'd22, 8'd32, "X", 8'd42, 8'd52, 8'd62, "Y",
        8'd72, 8'd82, 8'd92, "Z", "S", 8'd20, "T"
    };

    // debounce is 200 throughout this table
    localparam scan_row_t SCRIPT [NUM_ROWS] = '{
        '{'{16'h0001, 32'd10},       1'b1, '{"1",   kmd_pkg::MODE_ONE}},
        '{'{16'h4000, 32'd20},       1'b1, '{"#",   kmd_pkg::MODE_ONE}},
        '{'{16'h0000, 32'd30},       1'b1, '{8'd0,  kmd_pkg::MODE_ONE}},
        '{'{16'h7FFF, 32'd40},       1'b1, '{8'd0,  kmd_pkg::MODE_ONE}},
        '{'{16'h8000, 32'd199},      1'b1, '{8'd0,  kmd_pkg::MODE_ONE}},
        '{'{16'h8000, 32'd200},      1'b1, '{8'd0,  kmd_pkg::MODE_TWO}},
        '{'{16'h8000, 32'd5000},     1'b1, '{8'd0,  kmd_pkg::MODE_TWO}},
        '{'{16'h0008, 32'd5010},     1'b1, '{"X",   kmd_pkg::MODE_TWO}},
        '{'{16'h1000, 32'd5020},     1'b1, '{"S",   kmd_pkg::MODE_TWO}},
        '{'{16'h2000, 32'd5030},     1'b1, '{8'd20, kmd_pkg::MODE_TWO}},
        '{'{16'h4000, 32'd5040},     1'b1, '{"T",   kmd_pkg::MODE_TWO}},
        '{'{16'h0001, 32'd5050},     1'b0, '0},
        '{'{16'hFFFF, 32'd5060},     1'b1, '{8'd0,  kmd_pkg::MODE_ONE}},
        '{'{16'h0000, 32'd5070},     1'b1, '{8'd0,  kmd_pkg::MODE_ONE}},
        '{'{16'h8000, 32'd5100},     1'b1, '{8'd0,  kmd_pkg::MODE_ONE}},
        '{'{16'h8000, 32'd5260},     1'b1, '{8'd0,  kmd_pkg::MODE_TWO}},
        '{'{16'h0000, 32'd5270},     1'b1, '{8'd0,  kmd_pkg::MODE_TWO}},
        '{'{16'h8000, 32'hFFFFFFFF}, 1'b1, '{8'd0,  kmd_pkg::MODE_ONE}},
        '{'{16'h0000, 32'd5},        1'b1, '{8'd0,  kmd_pkg::MODE_ONE}},
        '{'{16'h8000, 32'd198},      1'b1, '{8'd0,  kmd_pkg::MODE_ONE}},
        '{'{16'h8000, 32'd199},      1'b1, '{8'd0,  kmd_pkg::MODE_TWO}},
        '{'{16'h0003, 32'd300},      1'b1, '{8'd0,  kmd_pkg::MODE_TWO}},
        '{'{16'h0800, 32'd310},      1'b0, '0},
        '{'{16'h8001, 32'd320},      1'b1, '{8'd0,  kmd_pkg::MODE_TWO}},
        '{'{16'h0100, 32'd330},      1'b0, '0}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    kmd_pkg::in_item_t   in_data;
    logic                out_valid;
    logic                out_ready;
    kmd_pkg::out_item_t  out_data;
    logic                cfg_wr_en;
    kmd_pkg::debounce_t  cfg_wr_data;

    // local copy of the decoder state
    kmd_pkg::debounce_t  dec_debounce;
    logic                dec_mode_two;
    logic [31:0]         dec_last_toggle;
    logic                dec_key_held;

    kmd_pkg::out_item_t  decoded_due [$];
    int                  tx_idle_pct;
    int                  rx_stall_pct;
    int                  scans_sent;
    int                  results_seen;
    int                  toggles_predicted;
    int                  mismatches;
    int                  quiet_cycles;

    keypad_matrix_decoder_two_modes dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic kmd_pkg::out_item_t decode_scan(input kmd_pkg::in_item_t scan);
        kmd_pkg::out_item_t res;
        logic [31:0]        elapsed;
        logic [14:0]        keys;
        res.key_code = 8'd0;
        if (scan.key_matrix[15])
        begin
            elapsed = scan.time_ms - dec_last_toggle;
            if (!dec_key_held && elapsed >= {16'd0, dec_debounce})
            begin
                dec_mode_two    = !dec_mode_two;
                dec_last_toggle = scan.time_ms;
                dec_key_held    = 1'b1;
                toggles_predicted++;
            end
        end
        else
        begin
            dec_key_held = 1'b0;
            keys = scan.key_matrix[14:0];
            if (keys != 15'd0 && (keys & (keys - 15'd1)) == 15'd0)
            begin
                for (int i = 0; i < 15; i++)
                    if (keys[i])
                        res.key_code = dec_mode_two ? KEYMAP_TWO[i] : KEYMAP_ONE[i];
            end
        end
        res.mode_now = dec_mode_two ? kmd_pkg::MODE_TWO : kmd_pkg::MODE_ONE;
        return res;
    endfunction

    // offer one scan, wait for the transfer, then queue what it should decode to
    task automatic send_scan(input kmd_pkg::in_item_t scan, input logic pinned,
                             input kmd_pkg::out_item_t want);
        kmd_pkg::out_item_t predicted;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= scan;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = decode_scan(scan);
        decoded_due.push_back(pinned ? want : predicted);
        scans_sent++;
    endtask

    task automatic wait_drained();
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_debounce(input kmd_pkg::debounce_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        dec_debounce = value;
    endtask

    // result side: random back-pressure and checking
    always @(posedge clk)
    begin : rx_side
        kmd_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (decoded_due.size() == 0)
            begin
                $display("%0t: unexpected result: key_code %0d mode_now %0d",
                         $time, out_data.key_code, out_data.mode_now);
                mismatches++;
            end
            else
            begin
                want = decoded_due.pop_front();
                if (out_data.key_code !== want.key_code)
                begin
                    $display("%0t: key_code mismatch: expected %0d, actual %0d",
                             $time, want.key_code, out_data.key_code);
                    mismatches++;
                end
                if (out_data.mode_now !== want.mode_now)
                begin
                    $display("%0t: mode_now mismatch: expected %0d, actual %0d",
                             $time, want.mode_now, out_data.mode_now);
                    mismatches++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("** keypad_matrix_decoder_two_modes: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int                 hold_left;
        int                 pick;
        int                 a;
        int                 b;
        int                 dbn;
        logic [15:0]        matrix;
        logic [31:0]        step;
        logic [31:0]        tick_now;
        kmd_pkg::debounce_t next_dbn;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        out_ready   <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        quiet_cycles      = 0;
        tx_idle_pct       = 0;
        rx_stall_pct      = 0;
        scans_sent        = 0;
        results_seen      = 0;
        toggles_predicted = 0;
        mismatches        = 0;
        dec_debounce      = kmd_pkg::DEBOUNCE_RESET;
        dec_mode_two      = 1'b0;
        dec_last_toggle   = 32'd0;
        dec_key_held      = 1'b0;
        hold_left         = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
            send_scan(SCRIPT[r].scan, SCRIPT[r].pinned, SCRIPT[r].want);
        in_valid <= 1'b0;
        tick_now = 32'd330;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: next_dbn = 16'd0;
                1: next_dbn = 16'hFFFF;
                2: next_dbn = 16'd1;
                3: next_dbn = kmd_pkg::debounce_t'($urandom_range(2, 65534));
                4: next_dbn = kmd_pkg::DEBOUNCE_RESET;
                default: next_dbn = kmd_pkg::debounce_t'($urandom_range(2, 600));
            endcase
            write_debounce(next_dbn);
            case (p % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 48;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 48;
                end
                default:
                begin
                    tx_idle_pct  = 23;
                    rx_stall_pct = 23;
                end
            endcase
            dbn = int'(dec_debounce);

            repeat (PHASE_SCANS)
            begin
                if (hold_left > 0)
                begin
                    // mode key kept down, sometimes with other keys
                    hold_left--;
                    matrix = 16'h8000;
                    if ($urandom_range(0, 3) == 0)
                        matrix = matrix | 16'($urandom);
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                        matrix = 16'h0001 << $urandom_range(0, 14);
                    else if (pick < 55)
                    begin
                        matrix    = 16'h8000;
                        hold_left = $urandom_range(0, 5);
                    end
                    else if (pick < 65)
                        matrix = 16'h0000;
                    else if (pick < 80)
                    begin
                        a = $urandom_range(0, 14);
                        b = (a + $urandom_range(1, 14)) % 15;
                        matrix = (16'($urandom) & 16'h7FFF) | (16'h0001 << a)
                                 | (16'h0001 << b);
                    end
                    else
                        matrix = 16'($urandom);
                end

                // tick steps clustered around the debounce window, rare big jumps
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    step = $urandom_range(0, dbn / 2 + 4);
                else if (pick < 95)
                    step = $urandom_range(dbn / 2, dbn * 2 + 2);
                else
                    step = $urandom;
                tick_now = tick_now + step;

                send_scan({matrix, tick_now}, 1'b0, '0);
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (6) @(posedge clk);

        $display("Scans: %0d sent, %0d results checked, %0d mode toggles predicted",
                 scans_sent, results_seen, toggles_predicted);
        $display("Debounce runs: reset 200, 0, 65535, 1, two random; four idle/stall mixes");
        if (mismatches == 0 && decoded_due.size() == 0)
            $display("** keypad_matrix_decoder_two_modes: PASSED **");
        else
            $display("** keypad_matrix_decoder_two_modes: FAILED **");
        $finish;
    end

endmodule
